/* hw/rtl/frst_pkg.sv */
// Shared types and constants for the Fenwick range-sum table.
// No dependencies; imported by frst_mem, frst_walk and the top level.
package frst_pkg;

    localparam int DATA_W = 32;   // tree word and delta width
    localparam int IDX_W  = 11;   // width of index and size fields

    // item kind codes
    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // memory port strobes
    typedef struct packed {
        logic wr;
        logic rd;
    } t_mem_ctl;

endpackage

/* hw/rtl/frst_mem.sv */
// Single-port-write, single-port-read tree store with registered read data.
// Depends on frst_pkg.
module frst_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                          i_clk,
    input  frst_pkg::t_mem_ctl            i_ctl,
    input  logic [AW-1:0]                 i_waddr,
    input  logic [frst_pkg::DATA_W-1:0]   i_wdata,
    input  logic [AW-1:0]                 i_raddr,
    output logic [frst_pkg::DATA_W-1:0]   o_rdata
);
    import frst_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/frst_walk.sv */
// Tree walk sequencer: clear sweep, update read-modify-write walk, and the
// two prefix walks of a range query, plus the result register.
// Depends on frst_pkg; drives one frst_mem.
module frst_walk #(
    parameter int MAX_POSITIONS = 1024,
    parameter int AW            = 10,
    parameter int PW            = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [PW-1:0]                 i_n,
    input  logic                          i_clear,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_in_kind,
    input  logic [frst_pkg::IDX_W-1:0]    i_in_first_index,
    input  logic [frst_pkg::IDX_W-1:0]    i_in_last_index,
    input  logic [frst_pkg::DATA_W-1:0]   i_in_delta,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [frst_pkg::DATA_W-1:0]   o_out_range_sum,
    output frst_pkg::t_mem_ctl            o_mem_ctl,
    output logic [AW-1:0]                 o_mem_waddr,
    output logic [frst_pkg::DATA_W-1:0]   o_mem_wdata,
    output logic [AW-1:0]                 o_mem_raddr,
    input  logic [frst_pkg::DATA_W-1:0]   i_mem_rdata
);
    import frst_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_UPD_RD, S_UPD_WR, S_QLO, S_QHI, S_DONE
    } t_state;

    t_state            r_state;
    logic [AW-1:0]     r_clr_addr;
    logic [PW-1:0]     r_pos;
    logic [PW-1:0]     r_hi_pos;
    logic [DATA_W-1:0] r_delta;
    logic [DATA_W-1:0] r_acc;
    logic              r_pend;
    logic              r_out_vld;
    logic [DATA_W-1:0] r_out_sum;

    logic [PW-1:0]     w_first;
    logic [PW-1:0]     w_last;
    logic [PW-1:0]     w_first_c;
    logic [PW-1:0]     w_last_c;
    logic [PW-1:0]     w_lowbit;
    logic [PW-1:0]     w_up_next;
    logic [AW-1:0]     w_pos_addr;
    logic              w_out_free;
    logic              w_load_out;

    assign w_first    = PW'(i_in_first_index);
    assign w_last     = PW'(i_in_last_index);
    assign w_first_c  = (w_first > i_n) ? i_n : w_first;
    assign w_last_c   = (w_last > i_n) ? i_n : w_last;
    assign w_lowbit   = r_pos & (PW'(0) - r_pos);
    assign w_up_next  = r_pos + w_lowbit;
    assign w_pos_addr = AW'(r_pos - PW'(1));
    assign w_out_free = !r_out_vld || !i_out_stall;
    assign w_load_out = !i_clear && (r_state == S_DONE) && w_out_free;

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_vld;
    assign o_out_range_sum = r_out_sum;

    // memory strobes
    assign o_mem_ctl.wr = (r_state == S_CLEAR) || (r_state == S_UPD_WR);
    assign o_mem_ctl.rd = (r_state == S_UPD_RD)
                       || (((r_state == S_QLO) || (r_state == S_QHI)) && (r_pos != '0));
    assign o_mem_waddr  = (r_state == S_CLEAR) ? r_clr_addr : w_pos_addr;
    assign o_mem_wdata  = (r_state == S_CLEAR) ? '0 : (i_mem_rdata + r_delta);
    assign o_mem_raddr  = w_pos_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_pend     <= 1'b0;
        end else begin
            if (i_clear) begin
                r_state    <= S_CLEAR;
                r_clr_addr <= '0;
                r_pend     <= 1'b0;
            end else begin
                unique case (r_state)
                    S_CLEAR: begin
                        r_clr_addr <= r_clr_addr + AW'(1);
                        if (r_clr_addr == AW'(MAX_POSITIONS - 1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                    S_IDLE: begin
                        if (i_in_valid) begin
                            r_delta <= i_in_delta;
                            r_acc   <= '0;
                            r_pend  <= 1'b0;
                            if (i_in_kind == KIND_ADD) begin
                                r_pos <= w_first;
                                if ((w_first != '0) && (w_first <= i_n)) begin
                                    r_state <= S_UPD_RD;
                                end
                            end else if (w_last_c < w_first_c) begin
                                r_state <= S_DONE;   // empty range sums to zero
                            end else begin
                                r_pos    <= (w_first_c == '0) ? '0 : (w_first_c - PW'(1));
                                r_hi_pos <= w_last_c;
                                r_state  <= S_QLO;
                            end
                        end
                    end
                    S_UPD_RD: begin
                        r_state <= S_UPD_WR;
                    end
                    S_UPD_WR: begin
                        r_pos   <= w_up_next;
                        r_state <= (w_up_next > i_n) ? S_IDLE : S_UPD_RD;
                    end
                    S_QLO, S_QHI: begin
                        // read issue and accumulate overlap: one entry a cycle
                        if (r_pos != '0) begin
                            r_pos  <= r_pos - w_lowbit;
                            r_pend <= 1'b1;
                        end else begin
                            r_pend <= 1'b0;
                        end
                        if (r_pend) begin
                            r_acc <= (r_state == S_QLO) ? (r_acc - i_mem_rdata)
                                                        : (r_acc + i_mem_rdata);
                        end
                        if ((r_pos == '0) && !r_pend) begin
                            if (r_state == S_QLO) begin
                                r_pos   <= r_hi_pos;
                                r_state <= S_QHI;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                    end
                    S_DONE: begin
                        if (w_out_free) begin
                            r_state <= S_IDLE;
                        end
                    end
                    default: begin
                        r_state <= S_IDLE;
                    end
                endcase
            end
        end
    end

    // result register: loads from the finished walk, empties on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_load_out) begin
            r_out_vld <= 1'b1;
            r_out_sum <= r_acc;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

endmodule

/* hw/rtl/fenwick_range_sum_table_top.sv */
// Fenwick range-sum table, top level: size register, tree store, walk sequencer.
// Depends on frst_pkg, frst_mem and frst_walk.
//
// Binary indexed tree over positions 1..N (N = size register, clamped to
// 1..MAX_POSITIONS) of 32-bit wrapping sums. One item is in work at a time.
// An add walks up the tree, reading each entry it touches and then writing
// it back, at most log2(N)+1 entries; an add at position zero or beyond N
// is dropped. A range query runs two prefix walks that issue one memory read
// a cycle with the accumulate overlapped; an empty range skips both walks.
// A query also waits in its done state while the previous result is still
// held in the output register by a stall. The single memory read port paces
// the walks. The finished sum sits in an output register, so a new item
// can start while the last result waits for transfer. After reset and after
// every write of the size register the store is swept to zero, one entry a
// cycle, all MAX_POSITIONS entries, with the input stalled for the whole
// sweep.
module fenwick_range_sum_table_top #(
    parameter int MAX_POSITIONS = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [frst_pkg::IDX_W-1:0]           i_cfg_wdata,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_in_kind,
    input  logic [frst_pkg::IDX_W-1:0]           i_in_first_index,
    input  logic [frst_pkg::IDX_W-1:0]           i_in_last_index,
    input  logic signed [frst_pkg::DATA_W-1:0]   i_in_delta,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [frst_pkg::DATA_W-1:0]   o_out_range_sum
);
    import frst_pkg::*;

    // store address width, and position width: holds 2*N during an upward
    // walk and every 11-bit field without loss
    localparam int AW   = $clog2(MAX_POSITIONS);
    localparam int PW_T = $clog2(MAX_POSITIONS) + 2;
    localparam int PW   = (PW_T > IDX_W + 1) ? PW_T : IDX_W + 1;

    logic [PW-1:0]     r_size;
    logic [PW-1:0]     w_cfg_val;
    logic [PW-1:0]     n_size;

    t_mem_ctl          w_mem_ctl;
    logic [AW-1:0]     w_mem_waddr;
    logic [AW-1:0]     w_mem_raddr;
    logic [DATA_W-1:0] w_mem_wdata;
    logic [DATA_W-1:0] w_mem_rdata;
    logic [DATA_W-1:0] w_out_sum;

    // size write clamps to 1..MAX_POSITIONS
    assign w_cfg_val = PW'(i_cfg_wdata);
    assign n_size    = (w_cfg_val == '0)               ? PW'(1) :
                       (w_cfg_val > PW'(MAX_POSITIONS)) ? PW'(MAX_POSITIONS) : w_cfg_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= PW'(MAX_POSITIONS);
        end else if (i_cfg_we) begin
            r_size <= n_size;
        end
    end

    frst_mem #(
        .DEPTH (MAX_POSITIONS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_ctl   (w_mem_ctl),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    // a size write also restarts the clearing sweep
    frst_walk #(
        .MAX_POSITIONS (MAX_POSITIONS),
        .AW            (AW),
        .PW            (PW)
    ) u_walk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_n              (r_size),
        .i_clear          (i_cfg_we),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_in_kind        (i_in_kind),
        .i_in_first_index (i_in_first_index),
        .i_in_last_index  (i_in_last_index),
        .i_in_delta       (i_in_delta),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_range_sum  (w_out_sum),
        .o_mem_ctl        (w_mem_ctl),
        .o_mem_waddr      (w_mem_waddr),
        .o_mem_wdata      (w_mem_wdata),
        .o_mem_raddr      (w_mem_raddr),
        .i_mem_rdata      (w_mem_rdata)
    );

    assign o_out_range_sum = w_out_sum;

`ifndef SYNTH
    // clearing sweep follows reset and size writes: input must be stalled
    a_stall_after_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall) else $error("input not stalled after reset");
    a_stall_after_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> o_in_stall) else $error("input not stalled after size write");
    a_no_out_after_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid) else $error("result valid after reset");
    a_size_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_size >= PW'(1)) && (r_size <= PW'(MAX_POSITIONS)))
        else $error("size register out of range");
    a_mem_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mem_ctl.wr && w_mem_ctl.rd) |-> (w_mem_waddr != w_mem_raddr))
        else $error("read and write to the same entry in one cycle");
`endif

endmodule

/* dv/tb_fenwick_range_sum_table_top.sv */
// Testbench for fenwick_range_sum_table_top: directed table plus random add/query traffic.
// Depends on frst_pkg and the RTL; predicts untyped range sums with its own Fenwick tree.
module tb_fenwick_range_sum_table_top;

    timeunit 1ns;
    timeprecision 1ps;

    import frst_pkg::*;

    localparam int MAX_POS    = 1024;
    localparam int SETTLE     = 64;      // settle wait, longer than the worst walk
    localparam int LIMIT      = 600000;  // cycle budget for the whole run
    localparam int PHASE_ITEMS = 68;     // items per size setting
    localparam int IDLE_PCT   = 29;

    // One row of the directed stimulus. has_sum marks rows whose answer is typed in.
    typedef struct packed {
        logic              kind;
        logic [IDX_W-1:0]  first;
        logic [IDX_W-1:0]  last;
        logic [DATA_W-1:0] delta;
        logic              has_sum;
        logic [DATA_W-1:0] sum;
    } t_stim_row;

    localparam int NROWS = 21;
    // Runs against the reset size of 1024.
    localparam t_stim_row DIRECTED [NROWS] = '{
        '{KIND_QUERY, 11'd1,    11'd1024, 32'h0,        1'b1, 32'h0}, // empty tree
        '{KIND_QUERY, 11'd0,    11'd0,    32'h0,        1'b1, 32'h0}, // left bound zero
        '{KIND_ADD,   11'd0,    11'd0,    32'h5,        1'b0, 32'h0}, // position zero, dropped
        '{KIND_ADD,   11'd1,    11'd0,    32'h7FFFFFFF, 1'b0, 32'h0},
        '{KIND_ADD,   11'd1024, 11'd0,    32'h80000000, 1'b0, 32'h0},
        '{KIND_ADD,   11'd1025, 11'd0,    32'h7,        1'b0, 32'h0}, // beyond N, dropped
        '{KIND_ADD,   11'd2047, 11'd2047, 32'hFFFFFFFF, 1'b0, 32'h0}, // beyond N, dropped
        '{KIND_QUERY, 11'd1,    11'd1,    32'h0,        1'b0, 32'h0},
        '{KIND_QUERY, 11'd0,    11'd2047, 32'hFFFFFFFF, 1'b0, 32'h0}, // right bound clamps
        '{KIND_QUERY, 11'd5,    11'd3,    32'h0,        1'b1, 32'h0}, // empty range
        '{KIND_QUERY, 11'd2047, 11'd2047, 32'h0,        1'b0, 32'h0}, // both bounds clamp
        '{KIND_QUERY, 11'd2047, 11'd0,    32'h0,        1'b1, 32'h0}, // clamps to empty
        '{KIND_ADD,   11'd512,  11'd0,    32'hFFFFFFFF, 1'b0, 32'h0},
        '{KIND_ADD,   11'd3,    11'd0,    32'd123,      1'b0, 32'h0},
        '{KIND_ADD,   11'd1023, 11'd0,    32'h40000000, 1'b0, 32'h0},
        '{KIND_QUERY, 11'd0,    11'd1023, 32'h0,        1'b0, 32'h0},
        '{KIND_QUERY, 11'd2,    11'd600,  32'h0,        1'b0, 32'h0},
        '{KIND_QUERY, 11'd1023, 11'd1024, 32'h0,        1'b0, 32'h0},
        '{KIND_QUERY, 11'd1024, 11'd1,    32'h0,        1'b1, 32'h0}, // empty range
        '{KIND_ADD,   11'd2,    11'd2047, 32'h0,        1'b0, 32'h0}, // add ignores last
        '{KIND_QUERY, 11'd513,  11'd1024, 32'h0,        1'b0, 32'h0}
    };

    // Size register values written between random phases; 0, 1025 and 2047 clamp.
    localparam int NSIZES = 10;
    localparam logic [IDX_W-1:0] SIZE_WRITES [NSIZES] = '{
        11'd1, 11'd0, 11'd2, 11'd5, 11'd37, 11'd2047, 11'd100, 11'd1025, 11'd16, 11'd1024
    };

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [IDX_W-1:0]         i_cfg_wdata;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic                     i_in_kind;
    logic [IDX_W-1:0]         i_in_first_index;
    logic [IDX_W-1:0]         i_in_last_index;
    logic signed [DATA_W-1:0] i_in_delta;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic signed [DATA_W-1:0] o_out_range_sum;

    fenwick_range_sum_table_top #(
        .MAX_POSITIONS (MAX_POS)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_in_kind        (i_in_kind),
        .i_in_first_index (i_in_first_index),
        .i_in_last_index  (i_in_last_index),
        .i_in_delta       (i_in_delta),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_range_sum  (o_out_range_sum)
    );

    // ---------------------------------------------------------------
    // Predictor: a plain Fenwick tree over 1..tree_size, wrapping sums.
    // ---------------------------------------------------------------
    logic [DATA_W-1:0] tree_sums [1:MAX_POS];
    int                tree_size;

    logic [DATA_W-1:0] pending_sums [$];  // range sums still owed by the block
    int                err_count;
    int                results_seen;
    int                cycle_count;
    bit                quiet_run;         // no random idling on either side while set

    function automatic void tree_clear();
        for (int k = 1; k <= MAX_POS; k++)
            tree_sums[k] = '0;
    endfunction

    function automatic void tree_add(input int pos, input logic [DATA_W-1:0] amount);
        int k;
        k = pos;
        while (k > 0 && k <= tree_size) begin
            tree_sums[k] = tree_sums[k] + amount;
            k = k + (k & -k);
        end
    endfunction

    function automatic logic [DATA_W-1:0] tree_prefix(input int pos);
        logic [DATA_W-1:0] acc;
        int k;
        acc = '0;
        k = pos;
        while (k > 0 && k <= MAX_POS) begin
            acc = acc + tree_sums[k];
            k = k - (k & -k);
        end
        return acc;
    endfunction

    // Both bounds clamp to N first; an inverted range sums to zero.
    function automatic logic [DATA_W-1:0] range_sum_of(input int lo, input int hi);
        int a;
        int b;
        a = (lo > tree_size) ? tree_size : lo;
        b = (hi > tree_size) ? tree_size : hi;
        if (b < a)
            return '0;
        return tree_prefix(b) - ((a > 0) ? tree_prefix(a - 1) : '0);
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("mismatch at result %0d: %s, got %08h expected %08h",
                 results_seen, what, got, want);
        err_count++;
    endtask

    // ---------------------------------------------------------------
    // Clock, cycle budget
    // ---------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("timeout after %0d cycles, %0d sums pending", cycle_count,
                     pending_sums.size());
            $display("[fenwick_range_sum_table_top] ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Result side: check each transfer against the oldest expected sum,
    // then pick the stall for the next cycle. Values read here are the
    // ones settled before this edge.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        logic [DATA_W-1:0] want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_sums.size() == 0) begin
                report_mismatch("range_sum with nothing pending", o_out_range_sum, '0);
            end else begin
                want = pending_sums.pop_front();
                if (o_out_range_sum !== want)
                    report_mismatch("range_sum", o_out_range_sum, want);
            end
            results_seen++;
        end
        i_out_stall <= quiet_run ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);
    end

    // ---------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------

    // Present one item and hold it until the transfer; the prediction is
    // taken at the transfer edge so the tree sees items in block order.
    task automatic drive_item(input logic kind, input logic [IDX_W-1:0] first,
                              input logic [IDX_W-1:0] last, input logic [DATA_W-1:0] delta,
                              input bit has_sum, input logic [DATA_W-1:0] sum);
        i_in_valid       <= 1'b1;
        i_in_kind        <= kind;
        i_in_first_index <= first;
        i_in_last_index  <= last;
        i_in_delta       <= delta;
        do @(posedge i_clk); while (o_in_stall);
        if (kind == KIND_ADD)
            tree_add(int'(first), delta);
        else
            pending_sums.push_back(has_sum ? sum : range_sum_of(int'(first), int'(last)));
    endtask

    // Random idle cycles after a transfer; payload is left as it was.
    task automatic sender_gap();
        if (!quiet_run) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
    endtask

    // Hold the input idle until every owed sum is out.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_sums.size() != 0)
            @(posedge i_clk);
    endtask

    // Size writes only on an idle block: results drained, trailing add walks
    // given time to finish, no clearing sweep in flight.
    task automatic write_size(input logic [IDX_W-1:0] value);
        int n;
        drain();
        repeat (SETTLE) @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        n = int'(value);
        if (n < 1)
            n = 1;
        if (n > MAX_POS)
            n = MAX_POS;
        tree_size = n;
        tree_clear();
    endtask

    // Mostly bounds near the live range, with the ends and the full field mixed in.
    function automatic logic [IDX_W-1:0] pick_index(input int n);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return IDX_W'($urandom_range(0, 2047));
        if (r < 16)
            return IDX_W'(n);
        if (r < 22)
            return '0;
        if (r < 28)
            return IDX_W'(1);
        return IDX_W'($urandom_range(0, (n + 1 > 2047) ? 2047 : n + 1));
    endfunction

    function automatic logic [DATA_W-1:0] pick_delta();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 32'h80000000;
        if (r < 20)
            return 32'h7FFFFFFF;
        if (r < 30)
            return 32'hFFFFFFFF;
        if (r < 55)
            return DATA_W'($urandom_range(0, 200) - 100);
        return $urandom;
    endfunction

    // One phase of random traffic at the current size. The caller idles the
    // input afterwards.
    task automatic random_phase();
        int                counted;
        bit                paused;
        logic              kind;
        logic [IDX_W-1:0]  a;
        logic [IDX_W-1:0]  b;
        logic [IDX_W-1:0]  t;
        counted = 0;
        paused  = 1'b0;
        while (counted < PHASE_ITEMS) begin
            kind = ($urandom_range(0, 99) < 45) ? KIND_ADD : KIND_QUERY;
            a    = pick_index(tree_size);
            b    = pick_index(tree_size);
            // most queries are well formed, the rest may come out empty
            if (kind == KIND_QUERY && a > b && $urandom_range(0, 99) < 70) begin
                t = a;
                a = b;
                b = t;
            end
            drive_item(kind, a, b, pick_delta(), 1'b0, '0);
            counted++;
            if (!paused && counted >= PHASE_ITEMS / 2) begin
                paused = 1'b1;
                drain();
            end else begin
                sender_gap();
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_wdata      <= '0;
        i_in_valid       <= 1'b0;
        i_in_kind        <= KIND_ADD;
        i_in_first_index <= '0;
        i_in_last_index  <= '0;
        i_in_delta       <= '0;
        quiet_run    = 1'b0;
        tree_size    = MAX_POS;
        tree_clear();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows at the reset size; the block sweeps first, drive_item waits.
        for (int r = 0; r < NROWS; r++) begin
            drive_item(DIRECTED[r].kind, DIRECTED[r].first, DIRECTED[r].last,
                       DIRECTED[r].delta, DIRECTED[r].has_sum, DIRECTED[r].sum);
            sender_gap();
        end

        random_phase();
        for (int s = 0; s < NSIZES; s++) begin
            write_size(SIZE_WRITES[s]);
            quiet_run = (s == 5);   // one full phase with no random idling
            random_phase();
            quiet_run = 1'b0;
        end

        drain();
        repeat (SETTLE) @(posedge i_clk);

        if (err_count == 0)
            $display("[fenwick_range_sum_table_top] OK");
        else
            $display("[fenwick_range_sum_table_top] ERROR");
        $finish;
    end

endmodule
